// ===== src/mbd_pkg.sv =====
// Package: sizes, register codes and lane control type for the 2x2 mip downsampler.
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

   // Level size bounds and channel format
   localparam int MAX_WIDTH      = 4096;
   localparam int MAX_HEIGHT     = 2048;
   localparam int CHANNEL_BITS   = 16;

   // Fixed register widths
   localparam int WIDTH_REG_BITS  = 13;
   localparam int HEIGHT_REG_BITS = 12;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 2;

   // Derived widths
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
   localparam int EFF_W_BITS     = COL_BITS + 1;
   localparam int EFF_H_BITS     = ROW_BITS + 1;
   localparam int LINE_DEPTH     = MAX_WIDTH / 2;
   localparam int LINE_ADDR_BITS = $clog2(LINE_DEPTH);
   localparam int PAIR_BITS      = CHANNEL_BITS + 1;
   localparam int SUM_BITS       = CHANNEL_BITS + 2;

   // Reset values of the size registers
   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(512);
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(256);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = CSR_INDEX_BITS'(1);

   // Per-pixel control from the position tracker to the channel lanes
   typedef struct packed {
      logic                      store_left;  // even column: latch pixel
      logic                      w_one;       // single column level
      logic                      h_one;       // single row level
      logic                      write;       // even row: park pair sum
      logic [LINE_ADDR_BITS-1:0] idx;         // line store slot
   } lane_ctl_type;

endpackage

`default_nettype wire

// ===== src/mbd_if.sv =====
// Interfaces: pixel request, pixel response and register write channels.
`timescale 1ns / 1ps
`default_nettype none

interface mbd_req_if;
   import mbd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;
   logic [CHANNEL_BITS-1:0] alpha_in;
   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface mbd_rsp_if;
   import mbd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_out;
   logic [CHANNEL_BITS-1:0] green_out;
   logic [CHANNEL_BITS-1:0] blue_out;
   logic [CHANNEL_BITS-1:0] alpha_out;
   logic                    level_done;
   modport source (output valid, red_out, green_out, blue_out, alpha_out, level_done,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, level_done,
                   output ready);
endinterface

interface mbd_csr_if;
   import mbd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/mbd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mbd_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/mbd_ctrl.sv =====
// Position tracker: size clamping, column/row counters and per-pixel decisions.
`timescale 1ns / 1ps
`default_nettype none

module mbd_ctrl import mbd_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [WIDTH_REG_BITS-1:0]  source_width,
   input  wire logic [HEIGHT_REG_BITS-1:0] source_height,
   output lane_ctl_type                    ctl,
   output logic                            emit,
   output logic                            done
);

   logic [COL_BITS-1:0]   column_count_ff, column_count_in;
   logic [ROW_BITS-1:0]   row_count_ff, row_count_in;
   logic [EFF_W_BITS-1:0] w_eff;
   logic [EFF_H_BITS-1:0] h_eff;
   logic [COL_BITS-1:0]   half_w;
   logic [ROW_BITS-1:0]   half_h;
   logic                  col_ok, row_ok, in_block, have_pair;
   logic [EFF_W_BITS-1:0] col_next;
   logic [EFF_H_BITS-1:0] row_next;
   logic [COL_BITS-1:0]   out_w;
   logic [ROW_BITS-1:0]   out_h;
   logic [ROW_BITS-2:0]   oy;

   // Clamp sizes: zero acts as one, oversize saturates
   always_comb begin
      if (source_width == '0) begin
         w_eff = EFF_W_BITS'(1);
      end else if (source_width > WIDTH_REG_BITS'(MAX_WIDTH)) begin
         w_eff = EFF_W_BITS'(MAX_WIDTH);
      end else begin
         w_eff = source_width[EFF_W_BITS-1:0];
      end
      if (source_height == '0) begin
         h_eff = EFF_H_BITS'(1);
      end else if (source_height > HEIGHT_REG_BITS'(MAX_HEIGHT)) begin
         h_eff = EFF_H_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = source_height[EFF_H_BITS-1:0];
      end
   end

   assign half_w    = w_eff[EFF_W_BITS-1:1];
   assign half_h    = h_eff[EFF_H_BITS-1:1];
   assign ctl.w_one = (w_eff == EFF_W_BITS'(1));
   assign ctl.h_one = (h_eff == EFF_H_BITS'(1));

   // Inside the area covered by whole 2x2 blocks
   assign col_ok = ctl.w_one ? (column_count_ff == '0)
                             : ({1'b0, column_count_ff[COL_BITS-1:1]} < half_w);
   assign row_ok = ctl.h_one ? (row_count_ff == '0)
                             : ({1'b0, row_count_ff[ROW_BITS-1:1]} < half_h);
   assign in_block = col_ok && row_ok;

   assign ctl.store_left = in_block && !ctl.w_one && !column_count_ff[0];
   assign have_pair      = in_block && (ctl.w_one || column_count_ff[0]);
   assign ctl.idx        = ctl.w_one ? '0 : column_count_ff[COL_BITS-1:1];
   assign ctl.write      = have_pair && !ctl.h_one && !row_count_ff[0];
   assign emit           = have_pair && (ctl.h_one || row_count_ff[0]);

   // Last block of the output level
   assign out_w = ctl.w_one ? COL_BITS'(1) : half_w;
   assign out_h = ctl.h_one ? ROW_BITS'(1) : half_h;
   assign oy    = ctl.h_one ? '0 : row_count_ff[ROW_BITS-1:1];
   assign done  = (({1'b0, ctl.idx} + COL_BITS'(1)) == out_w) &&
                  (({1'b0, oy} + ROW_BITS'(1)) == out_h);

   // Raster position advance with wrap at the level bounds
   always_comb begin
      col_next        = {1'b0, column_count_ff} + EFF_W_BITS'(1);
      row_next        = {1'b0, row_count_ff} + EFF_H_BITS'(1);
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            column_count_in = '0;
            row_count_in    = (row_next >= h_eff) ? '0 : row_next[ROW_BITS-1:0];
         end else begin
            column_count_in = col_next[COL_BITS-1:0];
            if ({1'b0, row_count_ff} >= h_eff) begin
               row_count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // A pair is either parked or completed, never both
   assert property (@(posedge clock) disable iff (reset) !(ctl.write && emit))
      else $error("pair both parked and emitted");
   // Even-column latch and pair completion exclude each other
   assert property (@(posedge clock) disable iff (reset) !(ctl.store_left && have_pair))
      else $error("left latch and pair at once");
   // A completed level returns both counters to the origin
   assert property (@(posedge clock) disable iff (reset)
      accept && emit && done && (col_next >= w_eff) && (row_next >= h_eff)
      |=> column_count_ff == '0 && row_count_ff == '0)
      else $error("counters not rewound at level end");

endmodule

`default_nettype wire

// ===== src/mbd_lane.sv =====
// Channel lane: horizontal pair sum, line store of even-row pairs, block mean.
`timescale 1ns / 1ps
`default_nettype none

module mbd_lane import mbd_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire lane_ctl_type            ctl,
   input  wire logic [CHANNEL_BITS-1:0] px,
   output logic      [CHANNEL_BITS-1:0] mean
);

   logic [CHANNEL_BITS-1:0] left_ff, left_in;
   logic [PAIR_BITS-1:0]    pair;
   logic [PAIR_BITS-1:0]    pair_ff;
   logic                    h_one_ff;
   logic [PAIR_BITS-1:0]    line_rd;
   logic [SUM_BITS-1:0]     total;

   // Even-column pixel waits for its right neighbor
   assign left_in = (load && ctl.store_left) ? px : left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   // Horizontal pair; a single column counts twice
   assign pair = ctl.w_one ? {px, 1'b0}
                           : ({1'b0, left_ff} + {1'b0, px});

   // Pair sums of the even row, read back on the odd row
   mbd_ram #(
      .WIDTH (PAIR_BITS),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (load && ctl.write),
      .wr_addr (ctl.idx),
      .wr_data (pair),
      .rd_en   (load),
      .rd_addr (ctl.idx),
      .rd_data (line_rd)
   );

   // Stage 1 operands
   always_ff @(posedge clock) begin
      if (load) begin
         pair_ff  <= pair;
         h_one_ff <= ctl.h_one;
      end
   end

   // Vertical sum; a single row counts twice. Mean is the sum over four.
   assign total = h_one_ff ? {pair_ff, 1'b0}
                           : ({1'b0, line_rd} + {1'b0, pair_ff});
   assign mean  = total[SUM_BITS-1:2];

endmodule

`default_nettype wire

// ===== src/mip_box_downsample_2x2.sv =====
// Top level: size registers, four channel lanes and the merging output register.
`timescale 1ns / 1ps
`default_nettype none

// 2x2 box-filter mip downsampler. Source RGBA pixels (unsigned Q8.8 per channel)
// enter in raster order, one per clock while the output is not stalled; each
// output pixel is the truncated mean of a 2x2 block, held in stage 1 and then in
// the output register, with level_done set on the last pixel of the level. A
// trailing odd column or row is consumed without output; a width or height of
// one reuses that column or row. Each channel lane has a 2048 x 17 line store
// (one write, one registered read port) for the pair sums of even rows; it needs
// no clearing after reset. Program source_width and source_height only while no
// request is in flight; a new level starts from the origin after the last pixel.
module mip_box_downsample_2x2 import mbd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   mbd_req_if.sink    req,
   mbd_rsp_if.source  rsp,
   mbd_csr_if.sink    csr
);

   logic [WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_BITS-1:0] height_ff, height_in;
   lane_ctl_type               ctl;
   logic                       emit, done;
   logic                       accept;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_done_ff;
   logic                       out_free;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_BITS-1:0]    red_mean, green_mean, blue_mean, alpha_mean;
   logic [CHANNEL_BITS-1:0]    red_ff, green_ff, blue_ff, alpha_ff;
   logic                       done_ff;

   // Size registers
   assign csr.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_SOURCE_WIDTH:  width_in  = csr.data[WIDTH_REG_BITS-1:0];
            REG_SOURCE_HEIGHT: height_in = csr.data[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Handshake: stage 1 drains into the output register whenever it is free
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || out_free;
   assign accept    = req.valid && req.ready;

   mbd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .source_width  (width_ff),
      .source_height (height_ff),
      .ctl           (ctl),
      .emit          (emit),
      .done          (done)
   );

   // Channel lanes
   mbd_lane u_red (
      .clock (clock), .reset (reset), .load (accept), .ctl (ctl),
      .px (req.red_in), .mean (red_mean)
   );
   mbd_lane u_green (
      .clock (clock), .reset (reset), .load (accept), .ctl (ctl),
      .px (req.green_in), .mean (green_mean)
   );
   mbd_lane u_blue (
      .clock (clock), .reset (reset), .load (accept), .ctl (ctl),
      .px (req.blue_in), .mean (blue_mean)
   );
   mbd_lane u_alpha (
      .clock (clock), .reset (reset), .load (accept), .ctl (ctl),
      .px (req.alpha_in), .mean (alpha_mean)
   );

   // Stage 1 occupancy: only block-completing requests occupy it
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = emit;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_done_ff <= done;
      end
   end

   // Merge the lane results into the output register
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         red_ff   <= red_mean;
         green_ff <= green_mean;
         blue_ff  <= blue_mean;
         alpha_ff <= alpha_mean;
         done_ff  <= s1_done_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.red_out    = red_ff;
   assign rsp.green_out  = green_ff;
   assign rsp.blue_out   = blue_ff;
   assign rsp.alpha_out  = alpha_ff;
   assign rsp.level_done = done_ff;

   // A new response always comes out of stage 1
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response without stage 1 result");
   // A block-completing request lands in stage 1
   assert property (@(posedge clock) disable iff (reset)
      accept && emit |=> s1_valid_ff)
      else $error("completed block lost");
   // A stalled stage 1 result is kept
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("stalled result dropped");

endmodule

`default_nettype wire

// ===== verif/tb_mip_box_downsample_2x2.sv =====
// Testbench for the 2x2 mip downsampler: stimulus, level predictor and response checker.
`timescale 1ns / 1ps

module tb_mip_box_downsample_2x2;
   import mbd_pkg::*;

   // Register indexes with no register behind them; writes must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_3 = CSR_INDEX_BITS'(3);

   localparam int SETTLE_CYCLES = 8;          // pipeline depth plus margin
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int RANDOM_PIXELS = 150;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic [CHANNEL_BITS-1:0] alpha;
   } rgba_type;

   typedef struct packed {
      rgba_type color;
      logic     level_done;
   } mip_px_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbd_req_if req_ch ();
   mbd_rsp_if rsp_ch ();
   mbd_csr_if csr_ch ();

   mip_box_downsample_2x2 dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Predictor state: size registers, line store of pair sums, left pixel, position
   logic [WIDTH_REG_BITS-1:0]  width_reg  = WIDTH_RESET;
   logic [HEIGHT_REG_BITS-1:0] height_reg = HEIGHT_RESET;
   logic [PAIR_BITS-1:0]       pair_line [4][LINE_DEPTH];
   logic [CHANNEL_BITS-1:0]    left_px [4];
   int                         col_pos = 0;
   int                         row_pos = 0;

   mip_px_type next_level_q [$];   // downsampled pixels still to come

   int  mismatches      = 0;
   int  pixels_sent     = 0;
   int  results_checked = 0;
   int  levels_done     = 0;
   int  cycle_count     = 0;
   bit  req_idle_on     = 1'b1;
   bit  rsp_idle_on     = 1'b1;
   int  rsp_hold_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, next_level_q.size());
         $display("FAIL mip_box_downsample_2x2");
         $finish;
      end
   end

   function automatic int clamp_size(input int v, input int bound);
      if (v == 0) return 1;
      if (v > bound) return bound;
      return v;
   endfunction

   function automatic int level_width();
      return clamp_size(int'(width_reg), MAX_WIDTH);
   endfunction

   function automatic int level_height();
      return clamp_size(int'(height_reg), MAX_HEIGHT);
   endfunction

   // Advance the predicted level by one accepted source pixel
   task automatic downsample_pixel(input rgba_type px);
      logic [CHANNEL_BITS-1:0] chan [4];
      logic [PAIR_BITS-1:0]    pair [4];
      logic [SUM_BITS-1:0]     total [4];
      int                      w, h, idx, ow, oh, oy, k;
      bit                      col_ok, row_ok, have_pair, emit;
      mip_px_type              res;
      chan[0] = px.red;
      chan[1] = px.green;
      chan[2] = px.blue;
      chan[3] = px.alpha;
      w = level_width();
      h = level_height();
      col_ok = (w == 1) ? (col_pos == 0) : (col_pos < 2 * (w / 2));
      row_ok = (h == 1) ? (row_pos == 0) : (row_pos < 2 * (h / 2));
      have_pair = 1'b0;
      emit = 1'b0;
      idx = (w == 1) ? 0 : col_pos / 2;

      // horizontal pair: single column doubles the pixel, else left + right
      if (col_ok && row_ok) begin
         if (w == 1) begin
            for (k = 0; k < 4; k++) pair[k] = {chan[k], 1'b0};
            have_pair = 1'b1;
         end else if (col_pos % 2 == 0) begin
            for (k = 0; k < 4; k++) left_px[k] = chan[k];
         end else begin
            for (k = 0; k < 4; k++) pair[k] = PAIR_BITS'(left_px[k]) + PAIR_BITS'(chan[k]);
            have_pair = 1'b1;
         end
      end

      // vertical: single row doubles the pair, even rows park it, odd rows add
      if (have_pair) begin
         if (h == 1) begin
            for (k = 0; k < 4; k++) total[k] = {pair[k], 1'b0};
            emit = 1'b1;
         end else if (row_pos % 2 == 0) begin
            for (k = 0; k < 4; k++) pair_line[k][idx] = pair[k];
         end else begin
            for (k = 0; k < 4; k++)
               total[k] = SUM_BITS'(pair_line[k][idx]) + SUM_BITS'(pair[k]);
            emit = 1'b1;
         end
      end

      if (emit) begin
         ow = (w == 1) ? 1 : w / 2;
         oh = (h == 1) ? 1 : h / 2;
         oy = (h == 1) ? 0 : row_pos / 2;
         res.color.red   = total[0][SUM_BITS-1:2];
         res.color.green = total[1][SUM_BITS-1:2];
         res.color.blue  = total[2][SUM_BITS-1:2];
         res.color.alpha = total[3][SUM_BITS-1:2];
         res.level_done  = (idx + 1 == ow) && (oy + 1 == oh);
         next_level_q.insert(next_level_q.size(), res);
      end

      // position update; counters wrap at or past the current bounds
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end else if (row_pos >= h) begin
         row_pos = 0;
      end
      if (col_pos == 0 && row_pos == 0) levels_done++;
   endtask

   function automatic int draw_gap(input bit on);
      if (!on || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic logic [CHANNEL_BITS-1:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CHANNEL_BITS'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic rgba_type rand_pixel();
      rgba_type px;
      px.red   = rand_chan();
      px.green = rand_chan();
      px.blue  = rand_chan();
      px.alpha = rand_chan();
      return px;
   endfunction

   function automatic rgba_type rgba(input logic [CHANNEL_BITS-1:0] r, g, b, a);
      rgba_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      px.alpha = a;
      return px;
   endfunction

   // One source pixel request; valid stays up when the next one follows at once
   task automatic send_pixel(input rgba_type px);
      int gap;
      gap = draw_gap(req_idle_on);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.red_in   <= px.red;
      req_ch.green_in <= px.green;
      req_ch.blue_in  <= px.blue;
      req_ch.alpha_in <= px.alpha;
      do @(posedge clock); while (!req_ch.ready);
      downsample_pixel(px);
      pixels_sent++;
   endtask

   // Random pixels until the position returns to the origin
   task automatic finish_level();
      do send_pixel(rand_pixel()); while (col_pos != 0 || row_pos != 0);
   endtask

   // Stop requests, wait for every pending result, then let the pipeline empty
   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      while (next_level_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves valid high so back-to-back writes need no extra edge
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (index == REG_SOURCE_WIDTH) width_reg = WIDTH_REG_BITS'(data);
      else if (index == REG_SOURCE_HEIGHT) height_reg = HEIGHT_REG_BITS'(data);
   endtask

   task automatic set_size(input int w, input int h);
      drain_and_settle();
      write_reg(REG_SOURCE_WIDTH, CSR_DATA_BITS'(w));
      write_reg(REG_SOURCE_HEIGHT, CSR_DATA_BITS'(h));
      csr_ch.valid <= 1'b0;
   endtask

   function automatic int pick_width();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return $urandom_range(13, 40);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   function automatic int pick_height();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return $urandom_range(9, 24);
         default: return $urandom_range(2, 8);
      endcase
   endfunction

   // Random small level; a broken one is resized part way and then completed.
   // Only used once the reset-size test has written the first 256 slots of the
   // line store, so every read after a resize hits a written slot.
   task automatic random_level(input bit broken);
      int area;
      set_size(pick_width(), pick_height());
      area = level_width() * level_height();
      if (broken && area > 1) begin
         repeat ($urandom_range(1, area - 1)) send_pixel(rand_pixel());
         set_size(pick_width(), pick_height());
      end
      finish_level();
   endtask

   // Response sink: random stalls, plus long hold-offs on request
   initial begin : rsp_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = draw_gap(rsp_idle_on);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid && rsp_hold_cycles == 0);
      end
   end

   task automatic check_field(input string name, input logic [CHANNEL_BITS-1:0] want_v,
                              input logic [CHANNEL_BITS-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   // Response checker: compare every accepted result with the oldest prediction
   always @(posedge clock) begin : check_rsp
      mip_px_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (next_level_q.size() == 0) begin
            $error("downsampled pixel with none pending");
            mismatches++;
         end else begin
            want = next_level_q.pop_front();
            check_field("red_out", want.color.red, rsp_ch.red_out);
            check_field("green_out", want.color.green, rsp_ch.green_out);
            check_field("blue_out", want.color.blue, rsp_ch.blue_out);
            check_field("alpha_out", want.color.alpha, rsp_ch.alpha_out);
            check_field("level_done", CHANNEL_BITS'(want.level_done),
                        CHANNEL_BITS'(rsp_ch.level_done));
            results_checked++;
         end
      end
   end

   // Reset sizes 512x256: one full row and the first block of the next, then
   // shrink and finish from there
   task automatic test_reset_size();
      repeat (512 + 2) send_pixel(rand_pixel());
      set_size(4, 4);
      finish_level();
   endtask

   // Directed corners: full scale, truncation, single pixel, single row/column,
   // odd trailing row and column, writes to unused register indexes
   task automatic test_corners();
      set_size(2, 2);
      repeat (4) send_pixel(rgba('1, '1, '1, '1));
      send_pixel(rgba(16'h0001, 16'h0003, 16'h8000, 16'h0000));
      send_pixel(rgba(16'h0001, 16'h0003, 16'h8000, 16'h0000));
      send_pixel(rgba(16'h0001, 16'h0003, 16'h7FFF, 16'h0000));
      send_pixel(rgba(16'h0000, 16'h0002, 16'h7FFF, 16'hFFFF));
      set_size(1, 1);
      send_pixel(rgba('1, 16'h0000, 16'h5A5A, 16'hA5A5));
      set_size(1, 2);
      finish_level();
      set_size(2, 1);
      finish_level();
      drain_and_settle();
      write_reg(REG_SPARE_2, '1);
      write_reg(REG_SPARE_3, '1);
      write_reg(REG_SPARE_2, '0);
      csr_ch.valid <= 1'b0;
      finish_level();
      set_size(3, 3);
      finish_level();
   endtask

   // Zero sizes and oversize register values that saturate; the oversize
   // levels run part way and are then resized and completed
   task automatic test_size_limits();
      set_size(0, 0);
      finish_level();
      set_size((1 << CSR_DATA_BITS) - 1, 1);
      repeat (8) send_pixel(rand_pixel());
      set_size(2, 2);
      finish_level();
      set_size(1, (1 << CSR_DATA_BITS) - 1);
      repeat (6) send_pixel(rand_pixel());
      set_size(MAX_WIDTH, 0);
      repeat (6) send_pixel(rand_pixel());
      set_size(3, 3);
      finish_level();
   endtask

   task automatic test_resize_mid_level();
      repeat (4) random_level(1'b1);
   endtask

   task automatic test_random_levels();
      int start;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         random_level($urandom_range(0, 5) == 0);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Long output hold-off under a full-rate source, then a source pause mid-level
   task automatic test_backpressure();
      set_size(8, 4);
      req_idle_on = 1'b0;
      rsp_hold_cycles = 200;
      finish_level();
      set_size(8, 4);
      repeat (12) send_pixel(rand_pixel());
      drain_and_settle();
      finish_level();
      req_idle_on = 1'b1;
   endtask

   initial begin
      req_ch.valid    <= 1'b0;
      req_ch.red_in   <= '0;
      req_ch.green_in <= '0;
      req_ch.blue_in  <= '0;
      req_ch.alpha_in <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= '0;
      csr_ch.data     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_size();
      test_corners();
      test_size_limits();
      test_resize_mid_level();
      test_random_levels();
      test_backpressure();

      drain_and_settle();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d source pixels over %0d levels, checked %0d downsampled pixels.",
               pixels_sent, levels_done, results_checked);
      $display("Reset size, 1x1 up to clamped oversize, mid-level resizes, stalls.");
      if (mismatches == 0 && next_level_q.size() == 0) begin
         $display("PASS mip_box_downsample_2x2");
      end else begin
         $display("FAIL mip_box_downsample_2x2");
      end
      $finish;
   end

endmodule
